// ===== design/pzeta_bisector_projection_defines.svh =====
// Assertion macros used by the asserting top module of the pzeta block.
`ifndef PZETA_BISECTOR_PROJECTION_DEFINES_SVH
`define PZETA_BISECTOR_PROJECTION_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define PZB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PZB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/pzb_pkg.sv =====
// Package with constants, types and the arctangent table of the pzeta block.
`timescale 1ns / 1ps
package pzb_pkg;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam logic [15:0] ZETA_WEIGHT_RESET = 16'd55706;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    typedef logic signed [33:0] cval_t;
    typedef logic signed [32:0] zval_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        case (idx)
            0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
            3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
            6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
            9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
            12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
            15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
            18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
            21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction
endpackage

// ===== design/pzb_cordic_stage.sv =====
// One registered CORDIC rotation step for three lanes with a stall enable.
`timescale 1ns / 1ps
module pzb_cordic_stage import pzb_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic  aclk,
    input  logic  en,
    input  cval_t x_in [3],
    input  cval_t y_in [3],
    input  zval_t z_in [3],
    output cval_t x_out [3],
    output cval_t y_out [3],
    output zval_t z_out [3]
);
    localparam zval_t ATAN = zval_t'({1'b0, atan_turn(IDX)});
    cval_t x_reg [3];
    cval_t y_reg [3];
    zval_t z_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (!z_in[k][32]) begin
                    x_reg[k] <= x_in[k] - (y_in[k] >>> IDX);
                    y_reg[k] <= y_in[k] + (x_in[k] >>> IDX);
                    z_reg[k] <= z_in[k] - ATAN;
                end else begin
                    x_reg[k] <= x_in[k] + (y_in[k] >>> IDX);
                    y_reg[k] <= y_in[k] - (x_in[k] >>> IDX);
                    z_reg[k] <= z_in[k] + ATAN;
                end
            end
        end
    end
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

// ===== design/pzeta_bisector_projection.sv =====
// Bisector projection of two lepton momenta and the missing energy, with pzeta. A beat can
// enter on every clock while the pipeline does not hold. Each beat passes one angle stage,
// one stage per CORDIC rotation (CORDIC_STAGES, at most 24), then the multiply, round,
// weight and final stages, and then the output skid buffer. The whole pipeline and the
// input hold only while the skid buffer has a beat nobody takes and the last stage has one.
`timescale 1ns / 1ps
`include "pzeta_bisector_projection_defines.svh"
module pzeta_bisector_projection import pzb_pkg::*; #(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [15:0]         s_lead_pt,
    input  logic signed [15:0]  s_lead_phi,
    input  logic [15:0]         s_sub_pt,
    input  logic signed [15:0]  s_sub_phi,
    input  logic [15:0]         s_miss_et,
    input  logic signed [15:0]  s_miss_phi,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [18:0]  m_pzeta_value,
    output logic signed [18:0]  m_visible_proj,
    output logic signed [17:0]  m_missing_proj
);
    localparam int NST  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int DEPTH = NST + 5;

    logic [15:0] zeta_weight_reg;
    logic [DEPTH-1:0] vld_reg;
    logic en;
    logic [1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) zeta_weight_reg <= ZETA_WEIGHT_RESET;
        else if (cfg_we) zeta_weight_reg <= cfg_wdata;
    end

    // Pipeline advances unless the skid buffer holds a beat, m_ready is low and the last stage holds a beat.
    assign en = (cnt_reg == 2'd0) || m_ready || !vld_reg[DEPTH-1];
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
    end

    // Stage 0: angle differences folded for CORDIC.
    function automatic logic [31:0] to_turn(input logic [16:0] a17);
        logic [31:0] w;
        logic [ANGLE_BITS-1:0] q;
        w = {a17, 15'd0};
        q = w[31 -: ANGLE_BITS];
        return {q, {(32 - ANGLE_BITS){1'b0}}};
    endfunction

    logic signed [17:0] diff, bis;
    logic [16:0] a17 [3];
    logic [31:0] t [3];
    cval_t x0 [3], y0 [3];
    zval_t z0 [3];
    logic neg0_reg [3];
    logic [15:0] pt_pipe [NST+1][3];
    logic neg_pipe [NST+1][3];
    cval_t x_st [NST+1][3], y_st [NST+1][3];
    zval_t z_st [NST+1][3];

    always_comb begin
        diff = 18'(s_lead_phi) - 18'(s_sub_phi);
        bis  = 18'(s_lead_phi) + 18'(s_sub_phi);
        if (diff > 18'sd32768 || diff < -18'sd32768) bis = bis + 18'sd65536;
        a17[0] = 17'((18'(s_lead_phi) <<< 1) - bis);
        a17[1] = 17'((18'(s_sub_phi) <<< 1) - bis);
        a17[2] = 17'((18'(s_miss_phi) <<< 1) - bis);
    end

    logic [31:0] tf [3];
    logic nf [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t[k] = to_turn(a17[k]);
            nf[k] = t[k][31] ^ t[k][30];
            tf[k] = nf[k] ? t[k] + 32'h80000000 : t[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                x0[k] <= GAIN_Q30;
                y0[k] <= '0;
                z0[k] <= zval_t'(signed'(tf[k]));
                neg0_reg[k] <= nf[k];
            end
            pt_pipe[0][0] <= s_lead_pt;
            pt_pipe[0][1] <= s_sub_pt;
            pt_pipe[0][2] <= s_miss_et;
        end
    end

    always_comb begin
        x_st[0] = x0; y_st[0] = y0; z_st[0] = z0;
        neg_pipe[0] = neg0_reg;
    end

    for (genvar g = 0; g < NST; g++) begin : g_rot
        pzb_cordic_stage #(.IDX(g)) u_stage (
            .aclk(aclk), .en(en),
            .x_in(x_st[g]), .y_in(y_st[g]), .z_in(z_st[g]),
            .x_out(x_st[g+1]), .y_out(y_st[g+1]), .z_out(z_st[g+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                pt_pipe[g+1] <= pt_pipe[g];
                neg_pipe[g+1] <= neg_pipe[g];
            end
        end
    end

    // Multiply stage.
    logic signed [50:0] prod_reg [3];
    cval_t cs [3];
    always_comb begin
        for (int k = 0; k < 3; k++)
            cs[k] = neg_pipe[NST][k] ? -x_st[NST][k] : x_st[NST][k];
    end
    always_ff @(posedge aclk) begin
        if (en)
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= 51'(cs[k]) * 51'(signed'({1'b0, pt_pipe[NST][k]}));
    end

    // Sum, round and saturate stage.
    logic signed [51:0] vs, ms;
    logic signed [21:0] vr, mr;
    logic signed [18:0] vis_reg;
    logic signed [17:0] miss_reg, miss2_reg;
    always_comb begin
        vs = 52'(prod_reg[0]) + 52'(prod_reg[1]) + (52'sd1 <<< 29);
        ms = 52'(prod_reg[2]) + (52'sd1 <<< 29);
        vr = 22'(vs >>> 30);
        mr = 22'(ms >>> 30);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            vis_reg  <= (vr > 22'sd262143) ? 19'sd262143 :
                        (vr < -22'sd262144) ? -19'sd262144 : 19'(vr);
            miss_reg <= (mr > 22'sd131071) ? 18'sd131071 :
                        (mr < -22'sd131072) ? -18'sd131072 : 18'(mr);
        end
    end

    // Weight stage.
    logic signed [36:0] wprod_reg;
    logic signed [18:0] vis2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            wprod_reg <= 37'(vis_reg) * 37'(signed'({1'b0, zeta_weight_reg}));
            vis2_reg  <= vis_reg;
            miss2_reg <= miss_reg;
        end
    end

    // Final stage.
    logic signed [21:0] pzr;
    logic signed [36:0] wr;
    logic signed [18:0] pz_reg, vis3_reg;
    logic signed [17:0] miss3_reg;
    always_comb begin
        wr  = (wprod_reg + 37'sd32768) >>> 16;
        pzr = 22'(wr) - 22'(miss2_reg);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            pz_reg <= (pzr > 22'sd262143) ? 19'sd262143 :
                      (pzr < -22'sd262144) ? -19'sd262144 : 19'(pzr);
            vis3_reg  <= vis2_reg;
            miss3_reg <= miss2_reg;
        end
    end

    // Output skid buffer, two entries.
    logic [55:0] fifo_reg [2];
    logic rd_ptr_reg, wr_ptr_reg;
    logic push, pop;
    assign push = en && vld_reg[DEPTH-1];
    assign pop  = m_valid && m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; rd_ptr_reg <= 1'b0; wr_ptr_reg <= 1'b0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wr_ptr_reg] <= {pz_reg, vis3_reg, miss3_reg};
    end
    assign m_valid = (cnt_reg != 2'd0);
    assign {m_pzeta_value, m_visible_proj, m_missing_proj} = fifo_reg[rd_ptr_reg];

    `PZB_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg != 2'd3, "skid overflow")
    `PZB_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "beat dropped")
    `PZB_ASSERT_IMP(a_full_stall, aclk, aresetn, cnt_reg == 2'd2 && !m_ready &&
        vld_reg[DEPTH-1], !s_ready, "push into full skid buffer")
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the pzeta bisector projection block.
`timescale 1ns / 1ps
module testbench;
    import pzb_pkg::*;

    typedef struct packed {
        logic [15:0] lead_pt;
        logic signed [15:0] lead_phi;
        logic [15:0] sub_pt;
        logic signed [15:0] sub_phi;
        logic [15:0] miss_et;
        logic signed [15:0] miss_phi;
    } event_t;

    typedef struct packed {
        logic signed [18:0] pzeta;
        logic signed [18:0] vis;
        logic signed [17:0] miss;
    } proj_t;

    localparam int ANGLE_W = 16;
    localparam int STAGES = 16;
    localparam int LIMIT_CYCLES = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    event_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [18:0] m_pzeta_value;
    logic signed [18:0] m_visible_proj;
    logic signed [17:0] m_missing_proj;

    event_t pending_events[$];
    proj_t expected_projs[$];
    logic [15:0] weight_model;
    int errors = 0;
    int checked = 0;
    int cycle_count = 0;
    int hold_off = 0;
    bit calm = 1'b0;
    bit stimulus_done = 1'b0;

    pzeta_bisector_projection i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_lead_pt(s_item.lead_pt), .s_lead_phi(s_item.lead_phi),
        .s_sub_pt(s_item.sub_pt), .s_sub_phi(s_item.sub_phi),
        .s_miss_et(s_item.miss_et), .s_miss_phi(s_item.miss_phi),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pzeta_value(m_pzeta_value), .m_visible_proj(m_visible_proj),
        .m_missing_proj(m_missing_proj)
    );

    always #4 aclk = ~aclk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [31:0] angle_to_turn(logic [16:0] a17);
        logic [31:0] q;
        q = {15'd0, a17};
        if (ANGLE_W < 17) q = q >> (17 - ANGLE_W);
        else q = q << (ANGLE_W - 17);
        q = q & ((32'd1 << ANGLE_W) - 1);
        return q << (32 - ANGLE_W);
    endfunction

    function automatic longint cordic_cosine(logic [31:0] t);
        longint x, y, z, xs, ys;
        bit flip;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (((t + 32'h40000000) & 32'h80000000) != 0) begin
            t = t + 32'h80000000;
            flip = 1'b1;
        end
        z = longint'($signed(t));
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_turn(i));
            end else begin
                x += ys; y -= xs; z += longint'(atan_turn(i));
            end
        end
        return flip ? -x : x;
    endfunction

    function automatic proj_t project_on_bisector(event_t e, logic [15:0] w);
        longint p1, p2, pm, bis, vis, miss, pz;
        proj_t r;
        p1 = e.lead_phi;
        p2 = e.sub_phi;
        pm = e.miss_phi;
        bis = p1 + p2;
        if (p1 - p2 > 32768 || p1 - p2 < -32768) bis += 65536;
        vis = longint'(e.lead_pt) * cordic_cosine(angle_to_turn(17'(2 * p1 - bis)))
            + longint'(e.sub_pt) * cordic_cosine(angle_to_turn(17'(2 * p2 - bis)));
        miss = longint'(e.miss_et) * cordic_cosine(angle_to_turn(17'(2 * pm - bis)));
        vis = clamp(floor_shift(vis + (64'sd1 <<< 29), 30), -262144, 262143);
        miss = clamp(floor_shift(miss + (64'sd1 <<< 29), 30), -131072, 131071);
        pz = clamp(floor_shift(longint'(w) * vis + 32768, 16) - miss, -262144, 262143);
        r.pzeta = 19'(pz);
        r.vis = 19'(vis);
        r.miss = 18'(miss);
        return r;
    endfunction

    function automatic event_t random_event();
        event_t e;
        e.lead_pt = 16'($urandom);
        e.sub_pt = 16'($urandom);
        e.miss_et = 16'($urandom);
        e.lead_phi = 16'($urandom);
        e.sub_phi = ($urandom_range(0, 3) == 0) ? 16'(e.lead_phi + 16'h8000) : 16'($urandom);
        e.miss_phi = 16'($urandom);
        if ($urandom_range(0, 9) == 0) e.lead_pt = 16'hFFFF;
        if ($urandom_range(0, 9) == 0) e.sub_pt = 16'hFFFF;
        return e;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_projs.push_back(project_on_bisector(s_item, weight_model));
            end
            if (!(s_valid && !s_ready)) begin
                if (pending_events.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
                    s_item <= pending_events.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                proj_t want;
                if (expected_projs.size() == 0) begin
                    $display("%0t: unexpected beat pzeta=%0d", $time, m_pzeta_value);
                    errors++;
                end else begin
                    want = expected_projs.pop_front();
                    checked++;
                    if (want.pzeta !== m_pzeta_value) begin
                        $display("%0t: pzeta expected %0d actual %0d", $time,
                            want.pzeta, m_pzeta_value);
                        errors++;
                    end
                    if (want.vis !== m_visible_proj) begin
                        $display("%0t: visible expected %0d actual %0d", $time,
                            want.vis, m_visible_proj);
                        errors++;
                    end
                    if (want.miss !== m_missing_proj) begin
                        $display("%0t: missing expected %0d actual %0d", $time,
                            want.miss, m_missing_proj);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || $urandom_range(0, 99) >= 11;
            end
        end
    end

    task automatic wait_drained();
        while (pending_events.size() > 0 || s_valid || expected_projs.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_weight(logic [15:0] w);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we <= 1'b0;
        weight_model = w;
    endtask

    initial begin
        event_t e;
        logic [15:0] weights[4];
        weight_model = ZETA_WEIGHT_RESET;
        weights = '{16'hFFFF, 16'h0000, 16'h8000, ZETA_WEIGHT_RESET};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        e = '{16'hFFFF, 16'sh0000, 16'hFFFF, 16'sh0000, 16'hFFFF, 16'sh7FFF};
        pending_events.push_back(e);
        e = '{16'hFFFF, 16'sh4000, 16'hFFFF, -16'sh4000, 16'h0000, 16'sh0000};
        pending_events.push_back(e);
        e = '{16'h1234, 16'sh4000, 16'h0100, 16'sh4001, 16'hFFFF, -16'sh8000};
        pending_events.push_back(e);
        e = '{16'hFFFF, 16'sh7FFF, 16'hFFFF, -16'sh8000, 16'hFFFF, 16'sh0000};
        pending_events.push_back(e);
        e = '{16'h0000, 16'sh0000, 16'h0000, 16'sh0000, 16'h0000, 16'sh0000};
        pending_events.push_back(e);
        e = '{16'hFFFF, 16'sh7FFF, 16'hFFFF, 16'sh7FFF, 16'hFFFF, -16'sh0001};
        pending_events.push_back(e);
        e = '{16'h8000, -16'sh8000, 16'h8000, -16'sh8000, 16'h8000, 16'sh7FFF};
        pending_events.push_back(e);
        e = '{16'h00FF, 16'sh2AAA, 16'hFF00, -16'sh5555, 16'h5555, 16'sh1111};
        pending_events.push_back(e);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            set_weight(weights[phase]);
            calm = (phase == 2);
            for (int n = 0; n < 450; n++) pending_events.push_back(random_event());
            if (phase == 1) begin
                repeat (20) @(posedge aclk);
                hold_off = 300;
            end
            wait_drained();
        end
        stimulus_done = 1'b1;
        $display("Checked %0d projection beats over four weight settings,", checked);
        $display("including extreme weights, opposite azimuths and output backpressure.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
